// ----- src/bbc_pkg.sv -----
package bbc_pkg;

  // Geometry of the cache
  localparam int SLOTS      = 4;
  localparam int BLOCK_BITS = 24;
  localparam int TAG_W      = (BLOCK_BITS < 24) ? BLOCK_BITS : 24;
  localparam int SLOT_IW    = $clog2(SLOTS);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes on the request channel
  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_ASSIGN = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_SAVE   = 3'd3;
  localparam logic [2:0] OP_EMPTY  = 3'd4;
  localparam logic [2:0] OP_FLUSH  = 3'd5;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_DONE  = 3'd3,
    ACT_NOBUF = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CMD_GET,
    CMD_ASSIGN,
    CMD_UPDATE,
    CMD_SAVE,
    CMD_EMPTY,
    CMD_FLUSH,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [23:0] blk_num;
  } req_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  slot;
    logic [23:0] block_tag;
    logic [24:0] sector;
    logic        hit;
    logic        last;
  } rsp_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [SLOTS-1:0] current;
  } back_status_t;

  // Lowest set bit: {found, index}
  function automatic logic [SLOT_IW:0] first_set(input logic [SLOTS-1:0] v);
    logic [SLOT_IW:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, SLOT_IW'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [SLOTS-1:0] one_hot(input logic [SLOT_IW-1:0] idx);
    return {{(SLOTS-1){1'b0}}, 1'b1} << idx;
  endfunction

  // Build one result item; slot keeps the low two index bits
  function automatic rsp_t make_rsp(input action_t act, input logic [SLOT_IW-1:0] idx,
                                    input logic [TAG_W-1:0] tag, input logic hit,
                                    input logic last);
    rsp_t                 r;
    logic [SLOT_IW+1:0]   idx_ext;
    logic [TAG_W+23:0]    tag_ext;
    idx_ext     = {2'b00, idx};
    tag_ext     = {24'd0, tag};
    r.action    = act;
    r.slot      = idx_ext[1:0];
    r.block_tag = tag_ext[23:0];
    r.sector    = {tag_ext[23:0], 1'b0};
    r.hit       = hit;
    r.last      = last;
    return r;
  endfunction

endpackage

// ----- src/block_buffer_cache_manager_top.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  bbc_pkg::req_t (operation, blk_num)
// rsp       out        rsp_valid / rsp_ready  bbc_pkg::rsp_t (action .. last)
//
// A hit, update, empty or unused code passes through queue pop, then execute;
// a miss adds load and finish; a dirty victim's write-back goes out in execute;
// save and flush scan one slot a cycle unless a dirty one waits on rsp_ready.
// The back-end sequencer handles one operation at a time.
// Reset clears valid, dirty and current marks, the command queue and the output register.
// A two-entry command queue lets requests be taken while the back end stalls on rsp_ready.
module block_buffer_cache_manager_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bbc_pkg::rsp_t rsp
);
  import bbc_pkg::*;

  logic         cmd_valid;
  logic         cmd_ready;
  cmd_t         cmd;
  back_status_t status;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_in    (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .status    (status)
  );

  // At most one slot is current
  a_current_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0(status.current))
    else $error("more than one current slot");

  // With current exclusive a victim always exists
  a_no_nobuf: assert property (@(posedge clk) disable iff (rst)
    !(rsp_valid && rsp.action == ACT_NOBUF))
    else $error("no buffer result issued");

  // A transfer that is not the last leaves the back end mid operation
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && !rsp.last) |=> (status.busy || (rsp_valid && rsp.last)))
    else $error("operation ended without a last result");

  // Output register empties on reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

// ----- src/bbc_front.sv -----
module bbc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bbc_pkg::req_t  req,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output bbc_pkg::cmd_t  cmd
);
  import bbc_pkg::*;

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              decoded;
  logic              push;
  logic              pop;

  // Classify the operation
  always_comb begin
    decoded.tag = req.blk_num[TAG_W-1:0];
    case (req.operation)
      OP_GET:    decoded.kind = CMD_GET;
      OP_ASSIGN: decoded.kind = CMD_ASSIGN;
      OP_UPDATE: decoded.kind = CMD_UPDATE;
      OP_SAVE:   decoded.kind = CMD_SAVE;
      OP_EMPTY:  decoded.kind = CMD_EMPTY;
      OP_FLUSH:  decoded.kind = CMD_FLUSH;
      default:   decoded.kind = CMD_NOP;
    endcase
  end

  assign req_ready = (count != QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

endmodule

// ----- src/bbc_back.sv -----
module bbc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  bbc_pkg::cmd_t         cmd_in,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output bbc_pkg::rsp_t         rsp,
  output bbc_pkg::back_status_t status
);
  import bbc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_LOAD  = 6'b000100,
    S_FIN   = 6'b001000,
    S_SAVE  = 6'b010000,
    S_SDONE = 6'b100000
  } state_t;

  state_t             state, state_next;
  cmd_t               cmd, cmd_next;
  logic [SLOT_IW-1:0] victim, victim_next;
  logic [SLOT_IW-1:0] scan, scan_next;
  logic [SLOTS-1:0]   valid, valid_next;
  logic [SLOTS-1:0]   dirty, dirty_next;
  logic [SLOTS-1:0]   current, current_next;
  logic [TAG_W-1:0]   tags [SLOTS];
  logic [TAG_W-1:0]   tag_wdata;
  logic               tag_we;
  logic [SLOTS-1:0]   hit_vec;
  logic [SLOT_IW:0]   hit_enc, inv_enc, nc_enc, cur_enc;
  logic               out_free;
  logic               emit;
  rsp_t               res;
  logic               rsp_valid_next;

  // Tag match and slot searches
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid[i] && (tags[i] == cmd.tag);
    end
  end

  assign hit_enc  = first_set(hit_vec);
  assign inv_enc  = first_set(~valid);
  assign nc_enc   = first_set(~current);
  assign cur_enc  = first_set(current);
  assign out_free = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == S_IDLE);
  assign status    = {(state != S_IDLE), current};

  // Sequencer
  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    victim_next  = victim;
    scan_next    = scan;
    valid_next   = valid;
    dirty_next   = dirty;
    current_next = current;
    tag_we       = 1'b0;
    tag_wdata    = cmd.tag;
    emit         = 1'b0;
    res          = make_rsp(ACT_DONE, '0, '0, 1'b0, 1'b1);
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_next   = cmd_in;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          case (cmd.kind)
            CMD_GET, CMD_ASSIGN: begin
              if (hit_enc[SLOT_IW]) begin
                current_next = one_hot(hit_enc[SLOT_IW-1:0]);
                emit         = 1'b1;
                res = make_rsp(ACT_DONE, hit_enc[SLOT_IW-1:0], cmd.tag, 1'b1, 1'b1);
              end else if (inv_enc[SLOT_IW] || nc_enc[SLOT_IW]) begin
                victim_next = inv_enc[SLOT_IW] ? inv_enc[SLOT_IW-1:0]
                                               : nc_enc[SLOT_IW-1:0];
                state_next  = S_LOAD;
                if (valid[victim_next] && dirty[victim_next]) begin
                  emit = 1'b1;
                  res  = make_rsp(ACT_WRITE, victim_next, tags[victim_next], 1'b0, 1'b0);
                end
              end else begin
                emit = 1'b1;
                res  = make_rsp(ACT_NOBUF, '0, '0, 1'b0, 1'b1);
              end
            end
            CMD_UPDATE: begin
              emit = 1'b1;
              if (cur_enc[SLOT_IW]) begin
                dirty_next[cur_enc[SLOT_IW-1:0]] = 1'b1;
                res = make_rsp(ACT_DONE, cur_enc[SLOT_IW-1:0], tags[cur_enc[SLOT_IW-1:0]],
                               1'b0, 1'b1);
              end
            end
            CMD_SAVE, CMD_FLUSH: begin
              scan_next  = '0;
              state_next = S_SAVE;
            end
            CMD_EMPTY: begin
              valid_next   = '0;
              dirty_next   = '0;
              current_next = '0;
              emit         = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_LOAD: begin
        if (out_free) begin
          emit                 = 1'b1;
          res = make_rsp((cmd.kind == CMD_GET) ? ACT_READ : ACT_FILL, victim, cmd.tag,
                         1'b0, 1'b0);
          valid_next[victim]   = 1'b1;
          dirty_next[victim]   = 1'b0;
          current_next         = one_hot(victim);
          tag_we               = 1'b1;
          state_next           = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          res        = make_rsp(ACT_DONE, victim, cmd.tag, 1'b0, 1'b1);
          state_next = S_IDLE;
        end
      end
      S_SAVE: begin
        // one slot per cycle; a dirty one waits for the output register
        if (!(valid[scan] && dirty[scan]) || out_free) begin
          if (valid[scan] && dirty[scan]) begin
            emit = 1'b1;
            res  = make_rsp(ACT_WRITE, scan, tags[scan], 1'b0, 1'b0);
          end
          dirty_next[scan] = 1'b0;
          if (scan == SLOT_IW'(SLOTS - 1)) begin
            state_next = S_SDONE;
          end else begin
            scan_next = scan + 1'b1;
          end
        end
      end
      S_SDONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (cmd.kind == CMD_FLUSH) begin
            valid_next   = '0;
            dirty_next   = '0;
            current_next = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid);

  // Control and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      dirty     <= '0;
      current   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      dirty     <= dirty_next;
      current   <= current_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    victim <= victim_next;
    scan   <= scan_next;
    if (tag_we) begin
      tags[victim] <= tag_wdata;
    end
    if (emit) begin
      rsp <= res;
    end
  end

endmodule
